// File: rtl/core/fess_pkg.sv
package fess_pkg;

    localparam int SEC_W = 64;
    localparam int US_W  = 20;
    localparam int CFG_W = 32;
    localparam int IDX_W = 1;

    localparam logic [US_W-1:0]  US_MAX            = 20'd999999;
    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST  = 32'd60;
    localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST = 32'd10;

    localparam logic [IDX_W-1:0] CFG_IDLE_TIMEOUT  = 1'b0;
    localparam logic [IDX_W-1:0] CFG_SCAN_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_US    = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic             seen;
        logic [SEC_W-1:0] high_sec;
        logic [US_W-1:0]  high_us;
        logic [SEC_W-1:0] scan_sec;
        logic [US_W-1:0]  scan_us;
    } t_state;

    typedef struct packed {
        t_status          status;
        logic             scan_now;
        logic [SEC_W-1:0] cutoff_sec;
        logic [US_W-1:0]  cutoff_us;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] idle_timeout;
        logic [CFG_W-1:0] scan_interval;
    } t_cfg;

endpackage

// File: rtl/core/fess_cfg.sv
module fess_cfg
    import fess_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout  <= IDLE_TIMEOUT_RST;
            r_cfg.scan_interval <= SCAN_INTERVAL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IDLE_TIMEOUT:  r_cfg.idle_timeout  <= i_cfg_data;
                CFG_SCAN_INTERVAL: r_cfg.scan_interval <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/fess_step.sv
module fess_step
    import fess_pkg::*;
(
    input  t_cfg             i_cfg,
    input  t_state           i_state,
    input  logic [SEC_W-1:0] i_ts_sec,
    input  logic [US_W-1:0]  i_ts_us,
    output t_state           o_state,
    output t_result          o_result
);

    logic             us_bad;
    logic             ts_newer;
    logic [SEC_W-1:0] nh_sec;
    logic [US_W-1:0]  nh_us;
    logic [SEC_W:0]   tgt_sum;
    logic             tgt_ovf;
    logic             reached;
    logic             due;
    logic [SEC_W:0]   cut_diff;
    logic             cut_unf;

    always_comb begin
        us_bad   = i_ts_us > US_MAX;
        ts_newer = ($signed(i_ts_sec) > $signed(i_state.high_sec))
                   || ((i_ts_sec == i_state.high_sec) && (i_ts_us > i_state.high_us));
        nh_sec   = ts_newer ? i_ts_sec : i_state.high_sec;
        nh_us    = ts_newer ? i_ts_us  : i_state.high_us;

        tgt_sum  = {i_state.scan_sec[SEC_W-1], i_state.scan_sec}
                   + {{(SEC_W+1-CFG_W){1'b0}}, i_cfg.scan_interval};
        tgt_ovf  = tgt_sum[SEC_W] ^ tgt_sum[SEC_W-1];
        reached  = ($signed(nh_sec) > $signed(tgt_sum[SEC_W-1:0]))
                   || ((nh_sec == tgt_sum[SEC_W-1:0]) && (nh_us >= i_state.scan_us));
        due      = !tgt_ovf && reached;

        cut_diff = {nh_sec[SEC_W-1], nh_sec}
                   - {{(SEC_W+1-CFG_W){1'b0}}, i_cfg.idle_timeout};
        cut_unf  = cut_diff[SEC_W] ^ cut_diff[SEC_W-1];

        o_state             = i_state;
        o_result.status     = ST_OK;
        o_result.scan_now   = 1'b0;
        o_result.cutoff_sec = '0;
        o_result.cutoff_us  = '0;

        priority if (us_bad) begin
            o_result.status = ST_BAD_US;
        end else if (!i_state.seen) begin
            o_state.seen     = 1'b1;
            o_state.high_sec = i_ts_sec;
            o_state.high_us  = i_ts_us;
            o_state.scan_sec = i_ts_sec;
            o_state.scan_us  = i_ts_us;
        end else if (due && cut_unf) begin
            o_result.status = ST_UNDERFLOW;
        end else begin
            o_state.high_sec = nh_sec;
            o_state.high_us  = nh_us;
            if (due) begin
                o_state.scan_sec    = nh_sec;
                o_state.scan_us     = nh_us;
                o_result.scan_now   = 1'b1;
                o_result.cutoff_sec = cut_diff[SEC_W-1:0];
                o_result.cutoff_us  = nh_us;
            end
        end
    end

endmodule

// File: rtl/core/flow_expiry_scan_scheduler.sv
// channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_ts_seconds, i_ts_micros
// out     | o_out_valid| i_out_stall | o_status, o_scan_now, o_cutoff_seconds, o_cutoff_micros
// cfg     | i_cfg_wr_en| -           | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls; each input passes the input register,
// then the result register. The scan state feedback (84-bit compare, 65-bit add and
// subtract) between the input register and the state/result registers sets fmax.
// Synchronous reset clears scan state and loads idle_timeout 60, scan_interval 10.
// o_in_stall rises only when both the input and the result register are full
// and the output is stalled.
module flow_expiry_scan_scheduler
    import fess_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SEC_W-1:0] i_ts_seconds,
    input  logic [US_W-1:0]         i_ts_micros,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic                    o_scan_now,
    output logic signed [SEC_W-1:0] o_cutoff_seconds,
    output logic [US_W-1:0]         o_cutoff_micros
);

    t_cfg             cfg;
    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    t_result          r_result;
    logic             r_in_vld;
    logic             r_out_vld;
    logic [SEC_W-1:0] r_ts_sec;
    logic [US_W-1:0]  r_ts_us;
    logic             out_ready;
    logic             adv;

    fess_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fess_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_ts_sec (r_ts_sec),
        .i_ts_us  (r_ts_us),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_ready;
    assign o_in_stall = r_in_vld && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (out_ready) begin
                r_in_vld <= 1'b0;
            end
            if (out_ready) begin
                r_out_vld <= r_in_vld;
            end
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_ts_sec <= i_ts_seconds;
            r_ts_us  <= i_ts_micros;
        end
        if (adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_result.status;
    assign o_scan_now       = r_result.scan_now;
    assign o_cutoff_seconds = r_result.cutoff_sec;
    assign o_cutoff_micros  = r_result.cutoff_us;

    a_due_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.scan_now) |-> (r_result.status == ST_OK))
        else $error("scan request with error status");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_result.status != ST_OK))
        |-> (r_result.cutoff_sec == '0 && r_result.cutoff_us == '0))
        else $error("error result carries cutoff");

    a_seen_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_ts_us <= US_MAX)) |=> r_state.seen)
        else $error("valid timestamp did not set seen");

    a_us_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_result.cutoff_us <= US_MAX && r_state.high_us <= US_MAX))
        else $error("microseconds out of range");

endmodule
